[rtl/core/windowed_ratio_median_estimator_defines.svh]
// assertion macros for the windowed ratio median estimator checker
`ifndef WINDOWED_RATIO_MEDIAN_ESTIMATOR_DEFINES_SVH
`define WINDOWED_RATIO_MEDIAN_ESTIMATOR_DEFINES_SVH

// same-cycle implication, clocked on clk_i, quiet in reset
`define WRME_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, quiet in reset
`define WRME_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wrme_pkg.sv]
// shared constants, types and helpers of the windowed ratio median estimator
package wrme_pkg;

  localparam int HISTORY_DEPTH   = 120;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RING_AW         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W           = $clog2(HISTORY_DEPTH + 1);
  localparam int MIN_FOR_MEDIAN  = 5;
  localparam logic [31:0] ONE_Q  = 32'(1) << RATIO_FRAC_BITS;

  localparam int DIV_N_W   = 32 + RATIO_FRAC_BITS + 1;
  localparam int DIV_D_W   = 33;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam logic [15:0] WIN_LEN_RST = 16'd100;
  localparam logic [15:0] MIN_REF_RST = 16'd10;

  typedef enum logic [0:0] {
    CFG_WIN_LEN = 1'b0,
    CFG_MIN_REF = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_LEARN_X,
    OP_LEARN_Y,
    OP_EQUIV_X,
    OP_EQUIV_Y
  } div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LX,
    ST_LX_WAIT,
    ST_LY,
    ST_LY_WAIT,
    ST_MED_INIT,
    ST_MED_SCAN,
    ST_MED_TAIL,
    ST_MED_BIT,
    ST_MED_DONE,
    ST_EX,
    ST_EX_WAIT,
    ST_EY,
    ST_EY_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic    acc;
    logic    snap;
    logic    div_go;
    div_op_e div_op;
    logic    div_save;
    logic    med_init;
    logic    med_rd;
    logic    med_bit;
    logic    med_done;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic       closed;
    logic [1:0] learn_ok;
    logic       div_done;
    logic       scan_last;
    logic       bit_zero;
    logic       out_free;
  } sts_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat_add16(input logic [31:0] a, input logic [15:0] d);
    logic [32:0] s;
    s = {a[31], a} + {{17{d[15]}}, d};
    if (s[32] != s[31]) begin
      sat_add16 = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_add16 = s[31:0];
    end
  endfunction

  function automatic logic [31:0] sat_sub32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      sat_sub32 = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      sat_sub32 = s[31:0];
    end
  endfunction

endpackage

[rtl/core/wrme_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module wrme_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [wrme_pkg::DIV_N_W-1:0]     dividend_i,
  input  logic [wrme_pkg::DIV_D_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [wrme_pkg::DIV_N_W-1:0]     quot_o
);

  logic                              run_q, run_d;
  logic                              done_q, done_d;
  logic [wrme_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;
  logic [wrme_pkg::DIV_D_W-1:0]      rem_q, rem_d;
  logic [wrme_pkg::DIV_N_W-1:0]      quo_q, quo_d;
  logic [wrme_pkg::DIV_D_W-1:0]      dvs_q;
  logic [wrme_pkg::DIV_D_W:0]        rem_sh;
  logic [wrme_pkg::DIV_D_W:0]        rem_sub;
  logic                              ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[wrme_pkg::DIV_N_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = wrme_pkg::DIV_CNT_W'(wrme_pkg::DIV_N_W);
      rem_d = '0;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = ge ? rem_sub[wrme_pkg::DIV_D_W-1:0] : rem_sh[wrme_pkg::DIV_D_W-1:0];
      quo_d = {quo_q[wrme_pkg::DIV_N_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == wrme_pkg::DIV_CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

[rtl/core/wrme_ctrl.sv]
// sequencing state machine of the estimator
module wrme_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  wrme_pkg::sts_t  sts_i,
  output logic            in_ready_o,
  output wrme_pkg::cmd_t  cmd_o
);

  wrme_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrme_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.div_op = wrme_pkg::OP_LEARN_X;
    in_ready_o = 1'b0;
    case (state_q)
      wrme_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          state_d   = wrme_pkg::ST_CHECK;
        end
      end
      wrme_pkg::ST_CHECK: begin
        cmd_o.snap = 1'b1;
        state_d    = sts_i.closed ? wrme_pkg::ST_LX : wrme_pkg::ST_EX;
      end
      wrme_pkg::ST_LX: begin
        if (sts_i.learn_ok[0]) begin
          cmd_o.div_go = 1'b1;
          cmd_o.div_op = wrme_pkg::OP_LEARN_X;
          state_d      = wrme_pkg::ST_LX_WAIT;
        end else begin
          state_d = wrme_pkg::ST_LY;
        end
      end
      wrme_pkg::ST_LX_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          state_d        = wrme_pkg::ST_LY;
        end
      end
      wrme_pkg::ST_LY: begin
        if (sts_i.learn_ok[1]) begin
          cmd_o.div_go = 1'b1;
          cmd_o.div_op = wrme_pkg::OP_LEARN_Y;
          state_d      = wrme_pkg::ST_LY_WAIT;
        end else begin
          state_d = wrme_pkg::ST_MED_INIT;
        end
      end
      wrme_pkg::ST_LY_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          state_d        = wrme_pkg::ST_MED_INIT;
        end
      end
      wrme_pkg::ST_MED_INIT: begin
        cmd_o.med_init = 1'b1;
        state_d        = wrme_pkg::ST_MED_SCAN;
      end
      wrme_pkg::ST_MED_SCAN: begin
        cmd_o.med_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = wrme_pkg::ST_MED_TAIL;
        end
      end
      wrme_pkg::ST_MED_TAIL: begin
        state_d = wrme_pkg::ST_MED_BIT;
      end
      wrme_pkg::ST_MED_BIT: begin
        cmd_o.med_bit = 1'b1;
        state_d = sts_i.bit_zero ? wrme_pkg::ST_MED_DONE : wrme_pkg::ST_MED_SCAN;
      end
      wrme_pkg::ST_MED_DONE: begin
        cmd_o.med_done = 1'b1;
        state_d        = wrme_pkg::ST_EX;
      end
      wrme_pkg::ST_EX: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = wrme_pkg::OP_EQUIV_X;
        state_d      = wrme_pkg::ST_EX_WAIT;
      end
      wrme_pkg::ST_EX_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          state_d        = wrme_pkg::ST_EY;
        end
      end
      wrme_pkg::ST_EY: begin
        cmd_o.div_go = 1'b1;
        cmd_o.div_op = wrme_pkg::OP_EQUIV_Y;
        state_d      = wrme_pkg::ST_EY_WAIT;
      end
      wrme_pkg::ST_EY_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.div_save = 1'b1;
          state_d        = wrme_pkg::ST_FIN;
        end
      end
      wrme_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = wrme_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrme_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/wrme_datapath.sv]
// window sums, ratio rings, median selection, divider and result register
module wrme_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [15:0]          ref_dx_i,
  input  logic [15:0]          ref_dy_i,
  input  logic [15:0]          meas_dx_i,
  input  logic [15:0]          meas_dy_i,
  input  logic                 meas_valid_i,
  input  logic [7:0]           elapsed_ms_i,
  input  wrme_pkg::cmd_t       cmd_i,
  output wrme_pkg::sts_t       sts_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 window_closed_o,
  output logic [319:0]         out_data_o
);

  localparam int F = wrme_pkg::RATIO_FRAC_BITS;
  localparam int N = wrme_pkg::DIV_N_W;

  logic [15:0] len_q, minr_q;
  logic [1:0][31:0] ref_acc_q, meas_acc_q;
  logic [15:0] age_q;
  logic [16:0] age_sum;
  logic [1:0][31:0] snap_ref_q, snap_meas_q;
  logic closed_q;
  logic [1:0][31:0] gain_q, equiv_q;
  logic [1:0][wrme_pkg::RING_AW-1:0] pos_q;
  logic [1:0][wrme_pkg::CNT_W-1:0] fill_q;
  logic [31:0] ring_q [2][wrme_pkg::HISTORY_DEPTH];
  logic [1:0] ring_we;
  logic [31:0] ring_wd;
  logic [1:0][31:0] rd_data_q;
  logic [wrme_pkg::RING_AW-1:0] addr_q, rd_addr_q;
  logic rd_vld_q;
  logic [4:0] bit_q;
  logic [31:0] hi_mask;
  logic [1:0][31:0] pre_lo_q, pre_hi_q;
  logic [1:0][wrme_pkg::CNT_W-1:0] k_lo_q, k_hi_q, c_lo_q, c_hi_q;
  logic [1:0][31:0] ref_mag;
  wrme_pkg::div_op_e op_q;
  logic lane;
  logic learn_op;
  logic [N-1:0] div_nd;
  logic [wrme_pkg::DIV_D_W-1:0] div_dv;
  logic div_done;
  logic [N-1:0] quot;
  logic [31:0] learn_q, eq_q;
  logic [31:0] meas_sel, gain_sel;
  logic [1:0] g_lane;
  logic out_vld_q, out_closed_q;
  logic [319:0] out_q;
  logic [32:0] avg_sum [2];

  assign age_sum = {1'b0, age_q} + {9'd0, elapsed_ms_i};
  assign hi_mask = ~(32'hFFFF_FFFF >> (5'd31 - bit_q));
  assign g_lane  = {(cmd_i.div_op == wrme_pkg::OP_EQUIV_Y) || (cmd_i.div_op == wrme_pkg::OP_LEARN_Y),
                    1'b0};
  assign meas_sel = g_lane[1] ? snap_meas_q[1] : snap_meas_q[0];
  assign gain_sel = g_lane[1] ? gain_q[1] : gain_q[0];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      ref_mag[l] = wrme_pkg::mag32(snap_ref_q[l]);
      avg_sum[l] = {1'b0, pre_lo_q[l]} + {1'b0, pre_hi_q[l]};
    end
    learn_op = (cmd_i.div_op == wrme_pkg::OP_LEARN_X) || (cmd_i.div_op == wrme_pkg::OP_LEARN_Y);
    if (learn_op) begin
      div_nd = {1'b0, wrme_pkg::mag32(meas_sel), F'(0)};
      div_dv = {1'b0, g_lane[1] ? ref_mag[1] : ref_mag[0]};
    end else begin
      div_nd = {wrme_pkg::mag32(meas_sel), (F + 1)'(0)} + N'(gain_sel);
      div_dv = {gain_sel, 1'b0};
    end
  end

  wrme_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_nd),
    .divisor_i  (div_dv),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    lane    = (op_q == wrme_pkg::OP_LEARN_Y) || (op_q == wrme_pkg::OP_EQUIV_Y);
    learn_q = (|quot[N-1:32]) ? 32'hFFFF_FFFF : quot[31:0];
    if ((lane ? snap_meas_q[1][31] : snap_meas_q[0][31])) begin
      if ((|quot[N-1:32]) || (quot[31] && (|quot[30:0]))) begin
        eq_q = 32'h8000_0000;
      end else begin
        eq_q = ~quot[31:0] + 32'd1;
      end
    end else begin
      eq_q = (|quot[N-1:31]) ? 32'h7FFF_FFFF : quot[31:0];
    end
    ring_wd = learn_q;
    ring_we = '0;
    if (cmd_i.div_save && (learn_q != 32'd0) &&
        ((op_q == wrme_pkg::OP_LEARN_X) || (op_q == wrme_pkg::OP_LEARN_Y))) begin
      ring_we[lane] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (ring_we[l]) begin
        ring_q[l][pos_q[l]] <= ring_wd;
      end
      rd_data_q[l] <= ring_q[l][addr_q];
    end
    rd_addr_q <= addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= wrme_pkg::WIN_LEN_RST;
      minr_q     <= wrme_pkg::MIN_REF_RST;
      ref_acc_q  <= '0;
      meas_acc_q <= '0;
      age_q      <= '0;
      closed_q   <= 1'b0;
      gain_q     <= {wrme_pkg::ONE_Q, wrme_pkg::ONE_Q};
      pos_q      <= '0;
      fill_q     <= '0;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      bit_q      <= '0;
      op_q       <= wrme_pkg::OP_LEARN_X;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (wrme_pkg::cfg_idx_e'(cfg_idx_i))
          wrme_pkg::CFG_WIN_LEN: len_q  <= cfg_data_i;
          wrme_pkg::CFG_MIN_REF: minr_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.acc) begin
        ref_acc_q[0] <= wrme_pkg::sat_add16(ref_acc_q[0], ref_dx_i);
        ref_acc_q[1] <= wrme_pkg::sat_add16(ref_acc_q[1], ref_dy_i);
        if (meas_valid_i) begin
          meas_acc_q[0] <= wrme_pkg::sat_add16(meas_acc_q[0], meas_dx_i);
          meas_acc_q[1] <= wrme_pkg::sat_add16(meas_acc_q[1], meas_dy_i);
        end
        age_q <= age_sum[16] ? 16'hFFFF : age_sum[15:0];
      end
      if (cmd_i.snap) begin
        closed_q <= sts_o.closed;
        if (sts_o.closed) begin
          ref_acc_q  <= '0;
          meas_acc_q <= '0;
          age_q      <= '0;
        end
      end
      if (cmd_i.div_go) begin
        op_q <= cmd_i.div_op;
      end
      for (int l = 0; l < 2; l++) begin
        if (ring_we[l]) begin
          pos_q[l] <= (pos_q[l] == wrme_pkg::RING_AW'(wrme_pkg::HISTORY_DEPTH - 1)) ?
                      '0 : pos_q[l] + 1'b1;
          if (fill_q[l] != wrme_pkg::CNT_W'(wrme_pkg::HISTORY_DEPTH)) begin
            fill_q[l] <= fill_q[l] + 1'b1;
          end
        end
        if (cmd_i.med_done) begin
          if (fill_q[l] < wrme_pkg::CNT_W'(wrme_pkg::MIN_FOR_MEDIAN)) begin
            gain_q[l] <= wrme_pkg::ONE_Q;
          end else begin
            gain_q[l] <= avg_sum[l][32:1];
          end
        end
      end
      rd_vld_q <= cmd_i.med_rd;
      if (cmd_i.med_init) begin
        bit_q  <= 5'd31;
        addr_q <= '0;
      end else if (cmd_i.med_rd) begin
        addr_q <= addr_q + 1'b1;
      end else if (cmd_i.med_bit) begin
        bit_q  <= bit_q - 1'b1;
        addr_q <= '0;
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // per-bit rank selection over the ring
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      if (cmd_i.med_init) begin
        pre_lo_q[l] <= '0;
        pre_hi_q[l] <= '0;
        c_lo_q[l]   <= '0;
        c_hi_q[l]   <= '0;
        k_hi_q[l]   <= fill_q[l] >> 1;
        k_lo_q[l]   <= fill_q[l][0] ? (fill_q[l] >> 1) : (fill_q[l] >> 1) - 1'b1;
      end else if (cmd_i.med_bit) begin
        c_lo_q[l] <= '0;
        c_hi_q[l] <= '0;
        if (k_lo_q[l] >= c_lo_q[l]) begin
          pre_lo_q[l][bit_q] <= 1'b1;
          k_lo_q[l] <= k_lo_q[l] - c_lo_q[l];
        end
        if (k_hi_q[l] >= c_hi_q[l]) begin
          pre_hi_q[l][bit_q] <= 1'b1;
          k_hi_q[l] <= k_hi_q[l] - c_hi_q[l];
        end
      end else if (rd_vld_q && (wrme_pkg::CNT_W'(rd_addr_q) < fill_q[l])) begin
        if ((((rd_data_q[l] ^ pre_lo_q[l]) & hi_mask) == 32'd0) && !rd_data_q[l][bit_q]) begin
          c_lo_q[l] <= c_lo_q[l] + 1'b1;
        end
        if ((((rd_data_q[l] ^ pre_hi_q[l]) & hi_mask) == 32'd0) && !rd_data_q[l][bit_q]) begin
          c_hi_q[l] <= c_hi_q[l] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      snap_ref_q  <= ref_acc_q;
      snap_meas_q <= meas_acc_q;
    end
    if (cmd_i.div_save && ((op_q == wrme_pkg::OP_EQUIV_X) || (op_q == wrme_pkg::OP_EQUIV_Y))) begin
      equiv_q[lane] <= eq_q;
    end
    if (cmd_i.load_out) begin
      out_closed_q <= closed_q;
      out_q <= {wrme_pkg::sat_sub32(snap_ref_q[1], equiv_q[1]),
                wrme_pkg::sat_sub32(snap_ref_q[0], equiv_q[0]),
                equiv_q[1], equiv_q[0], gain_q[1], gain_q[0],
                snap_meas_q[1], snap_meas_q[0], snap_ref_q[1], snap_ref_q[0]};
    end
  end

  always_comb begin
    sts_o.closed      = age_q >= len_q;
    sts_o.learn_ok[0] = (ref_mag[0] != 32'd0) && (ref_mag[0] >= {16'd0, minr_q});
    sts_o.learn_ok[1] = (ref_mag[1] != 32'd0) && (ref_mag[1] >= {16'd0, minr_q});
    sts_o.div_done    = div_done;
    sts_o.scan_last   = addr_q == wrme_pkg::RING_AW'(wrme_pkg::HISTORY_DEPTH - 1);
    sts_o.bit_zero    = bit_q == 5'd0;
    sts_o.out_free    = !out_vld_q || out_ready_i;
  end

  assign out_valid_o     = out_vld_q;
  assign window_closed_o = out_closed_q;
  assign out_data_o      = out_q;

endmodule

[rtl/core/windowed_ratio_median_estimator.sv]
// top level of the windowed ratio median estimator
//
// the slave stream takes one sample per beat: reference and measured deltas
// and the elapsed time; tuser flags the measured deltas as valid. every beat
// gives exactly one result beat on the master stream: the window sums, the
// per-axis gains, measured sums scaled by the gains, and the differences.
// tuser on the result marks a beat that closed the window.
// one sample is in work at a time. an ordinary beat runs two 49-step
// divisions on the shared one-bit-per-cycle divider; a beat that closes
// the window adds up to two more divisions and a median pass over the
// ratio rings. the result sits in an output register; the next sample is
// taken while it waits, and work stalls only at the final load if the
// receiver holds off. reset clears sums, age, ring fill and the gains to
// 1.0; rings need no clearing since only filled entries are read.
// configuration is written through the plain write port; the user must
// write it only while the block is idle, the block does not enforce this.
module windowed_ratio_median_estimator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // ref_dx, ref_dy, meas_dx, meas_dy, elapsed_ms
  input  logic [71:0]   s_axis_tdata_i,
  // meas_valid
  input  logic [0:0]    s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // ref_sum_x, ref_sum_y, meas_sum_x, meas_sum_y, gain_x, gain_y,
  // equiv_x, equiv_y, diff_x, diff_y
  output logic [319:0]  m_axis_tdata_o,
  // window_closed
  output logic [0:0]    m_axis_tuser_o
);

  wrme_pkg::cmd_t cmd;
  wrme_pkg::sts_t sts;

  wrme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  wrme_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .ref_dx_i        (s_axis_tdata_i[15:0]),
    .ref_dy_i        (s_axis_tdata_i[31:16]),
    .meas_dx_i       (s_axis_tdata_i[47:32]),
    .meas_dy_i       (s_axis_tdata_i[63:48]),
    .meas_valid_i    (s_axis_tuser_i[0]),
    .elapsed_ms_i    (s_axis_tdata_i[71:64]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .window_closed_o (m_axis_tuser_o[0]),
    .out_data_o      (m_axis_tdata_o)
  );

endmodule

[rtl/core/wrme_checker.sv]
// port-level checks of the estimator, bound to the top level
`include "windowed_ratio_median_estimator_defines.svh"

module wrme_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  input  logic          s_axis_tvalid_i,
  input  logic          s_axis_tready_o,
  input  logic [71:0]   s_axis_tdata_i,
  input  logic [0:0]    s_axis_tuser_i,
  input  logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  input  logic [319:0]  m_axis_tdata_o,
  input  logic [0:0]    m_axis_tuser_o
);

  `WRME_AST_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result beat dropped or changed while stalled")

  `WRME_AST_NXT(a_busy_after_take, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "sample taken while previous one still in work")

  `WRME_AST_IMP(a_gain_nonzero, m_axis_tvalid_o, (m_axis_tdata_o[159:128] != 32'd0) && (m_axis_tdata_o[191:160] != 32'd0), "zero gain on result beat")

  `WRME_AST_NXT(a_no_early_result, s_axis_tvalid_i && s_axis_tready_o && !m_axis_tvalid_o, !m_axis_tvalid_o, "result appeared one cycle after sample")

endmodule

bind windowed_ratio_median_estimator wrme_checker u_wrme_checker (.*);

[verif/windowed_ratio_median_estimator_test.sv]
// testbench for the windowed ratio median estimator: predicts every result beat and compares it
`timescale 1ns / 100ps

module windowed_ratio_median_estimator_test;

  localparam longint CYCLE_LIMIT = 64'd16_000_000;
  localparam int DRAIN_CYCLES = 4500;

  typedef struct packed {
    logic signed [15:0] ref_dx;
    logic signed [15:0] ref_dy;
    logic signed [15:0] meas_dx;
    logic signed [15:0] meas_dy;
    logic               meas_valid;
    logic [7:0]         elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic        closed;
    logic [31:0] ref_sum_x;
    logic [31:0] ref_sum_y;
    logic [31:0] meas_sum_x;
    logic [31:0] meas_sum_y;
    logic [31:0] gain_x;
    logic [31:0] gain_y;
    logic [31:0] equiv_x;
    logic [31:0] equiv_y;
    logic [31:0] diff_x;
    logic [31:0] diff_y;
  } estimate_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we;
  wrme_pkg::cfg_idx_e cfg_idx;
  logic [15:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [71:0]  s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [319:0] m_tdata;
  logic [0:0]   m_tuser;

  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];
  sample_t   cur_sample;
  int        tx_gap, rx_hold, rx_stall, rx_beats, mismatch_count;
  bit        tx_burst;
  longint    cycle_count;

  // predictor state
  int unsigned win_len, min_ref;
  longint      acc_ref_x, acc_ref_y, acc_meas_x, acc_meas_y;
  int unsigned age;
  logic [31:0] ratio_hist[2][wrme_pkg::HISTORY_DEPTH];
  int unsigned hist_pos[2];
  logic [31:0] gain_now[2];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  windowed_ratio_median_estimator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void learn_ratio(int ax, longint ref_sum, longint meas_sum);
    longint r, m, q;
    r = magnitude(ref_sum);
    m = magnitude(meas_sum);
    if (r == 0 || r < min_ref) return;
    q = (m << wrme_pkg::RATIO_FRAC_BITS) / r;
    if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    if (q == 0) return;
    if (hist_pos[ax] >= wrme_pkg::HISTORY_DEPTH) hist_pos[ax] = 0;
    ratio_hist[ax][hist_pos[ax]] = q[31:0];
    hist_pos[ax] = (hist_pos[ax] + 1) % wrme_pkg::HISTORY_DEPTH;
  endfunction

  function automatic logic [31:0] median_of(int ax);
    logic [31:0] vals[$];
    int n;
    longint s;
    for (int i = 0; i < wrme_pkg::HISTORY_DEPTH; i++) begin
      if (ratio_hist[ax][i] != 0) vals = {vals, ratio_hist[ax][i]};
    end
    vals.sort();
    n = vals.size();
    if (n < wrme_pkg::MIN_FOR_MEDIAN) return wrme_pkg::ONE_Q;
    if (n % 2 == 1) return vals[n / 2];
    s = (longint'(vals[n / 2 - 1]) + longint'(vals[n / 2])) / 2;
    return s[31:0];
  endfunction

  function automatic longint scaled_meas(longint meas, logic [31:0] gain);
    longint m, g, q;
    m = magnitude(meas);
    g = (gain == 0) ? longint'(wrme_pkg::ONE_Q) : longint'(gain);
    q = ((m << (wrme_pkg::RATIO_FRAC_BITS + 1)) + g) / (2 * g);
    if (meas < 0) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return clamp32(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q;
  endfunction

  function automatic estimate_t predict_estimate(sample_t smp);
    estimate_t est;
    longint rx, ry, mx, my, ex, ey, dx, dy;
    acc_ref_x = clamp32(acc_ref_x + longint'(smp.ref_dx));
    acc_ref_y = clamp32(acc_ref_y + longint'(smp.ref_dy));
    if (smp.meas_valid) begin
      acc_meas_x = clamp32(acc_meas_x + longint'(smp.meas_dx));
      acc_meas_y = clamp32(acc_meas_y + longint'(smp.meas_dy));
    end
    age = age + smp.elapsed_ms;
    if (age > 65535) age = 65535;
    rx = acc_ref_x;
    ry = acc_ref_y;
    mx = acc_meas_x;
    my = acc_meas_y;
    est.closed = (age >= win_len);
    if (est.closed) begin
      learn_ratio(0, rx, mx);
      learn_ratio(1, ry, my);
      gain_now[0] = median_of(0);
      gain_now[1] = median_of(1);
      acc_ref_x = 0;
      acc_ref_y = 0;
      acc_meas_x = 0;
      acc_meas_y = 0;
      age = 0;
    end
    ex = scaled_meas(mx, gain_now[0]);
    ey = scaled_meas(my, gain_now[1]);
    dx = clamp32(rx - ex);
    dy = clamp32(ry - ey);
    est.ref_sum_x = rx[31:0];
    est.ref_sum_y = ry[31:0];
    est.meas_sum_x = mx[31:0];
    est.meas_sum_y = my[31:0];
    est.gain_x = gain_now[0];
    est.gain_y = gain_now[1];
    est.equiv_x = ex[31:0];
    est.equiv_y = ey[31:0];
    est.diff_x = dx[31:0];
    est.diff_y = dy[31:0];
    return est;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("beat %0d: %s got %h want %h", rx_beats, field, got, want);
    mismatch_count++;
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
      tx_gap <= 0;
      tx_burst <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_estimates = {expected_estimates, predict_estimate(cur_sample)};
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          cur_sample = pending_samples.pop_front();
          s_tdata <= {cur_sample.elapsed_ms, cur_sample.meas_dy, cur_sample.meas_dx,
                      cur_sample.ref_dy, cur_sample.ref_dx};
          s_tuser <= cur_sample.meas_valid;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 19) == 0) tx_burst <= !tx_burst;
          tx_gap <= tx_burst ? 0 : $urandom_range(0, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off so the input side backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_stall <= 0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
    end else if (m_tvalid && m_tready && rx_beats == 30) begin
      rx_stall <= 600;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t want, got;
    if (!rst_ni) begin
      m_tready <= 1'b0;
      rx_hold <= 0;
      rx_beats <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
               m_tdata[159:128], m_tdata[191:160], m_tdata[223:192], m_tdata[255:224],
               m_tdata[287:256], m_tdata[319:288]};
        if (expected_estimates.size() == 0) begin
          report_mismatch("unexpected result beat", 32'd1, 32'd0);
        end else begin
          want = expected_estimates.pop_front();
          if (got.closed != want.closed) report_mismatch("window_closed", got.closed, want.closed);
          if (got.ref_sum_x != want.ref_sum_x) report_mismatch("ref_sum_x", got.ref_sum_x, want.ref_sum_x);
          if (got.ref_sum_y != want.ref_sum_y) report_mismatch("ref_sum_y", got.ref_sum_y, want.ref_sum_y);
          if (got.meas_sum_x != want.meas_sum_x)
            report_mismatch("meas_sum_x", got.meas_sum_x, want.meas_sum_x);
          if (got.meas_sum_y != want.meas_sum_y)
            report_mismatch("meas_sum_y", got.meas_sum_y, want.meas_sum_y);
          if (got.gain_x != want.gain_x) report_mismatch("gain_x", got.gain_x, want.gain_x);
          if (got.gain_y != want.gain_y) report_mismatch("gain_y", got.gain_y, want.gain_y);
          if (got.equiv_x != want.equiv_x) report_mismatch("equiv_x", got.equiv_x, want.equiv_x);
          if (got.equiv_y != want.equiv_y) report_mismatch("equiv_y", got.equiv_y, want.equiv_y);
          if (got.diff_x != want.diff_x) report_mismatch("diff_x", got.diff_x, want.diff_x);
          if (got.diff_y != want.diff_y) report_mismatch("diff_y", got.diff_y, want.diff_y);
        end
        rx_beats <= rx_beats + 1;
        m_tready <= 1'b0;
        rx_hold <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        m_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic add_sample(int rdx, int rdy, int mdx, int mdy, bit mv, int el);
    sample_t smp;
    smp.ref_dx = 16'(rdx);
    smp.ref_dy = 16'(rdy);
    smp.meas_dx = 16'(mdx);
    smp.meas_dy = 16'(mdy);
    smp.meas_valid = mv;
    smp.elapsed_ms = 8'(el);
    pending_samples = {pending_samples, smp};
  endtask

  function automatic int rand_delta();
    int v;
    if ($urandom_range(0, 7) == 0) return int'($signed(16'($urandom)));
    v = $urandom_range(0, 300);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic add_random(int count, int el_max);
    repeat (count) begin
      add_sample(rand_delta(), rand_delta(), rand_delta(), rand_delta(),
                 $urandom_range(0, 5) != 0, $urandom_range(0, el_max));
    end
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || s_tvalid || expected_estimates.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(wrme_pkg::cfg_idx_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == wrme_pkg::CFG_WIN_LEN) win_len = {16'd0, value};
    else min_ref = {16'd0, value};
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_idx = wrme_pkg::CFG_WIN_LEN;
    cfg_data = '0;
    m_tready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    win_len = {16'd0, wrme_pkg::WIN_LEN_RST};
    min_ref = {16'd0, wrme_pkg::MIN_REF_RST};
    acc_ref_x = 0;
    acc_ref_y = 0;
    acc_meas_x = 0;
    acc_meas_y = 0;
    age = 0;
    foreach (ratio_hist[a, i]) ratio_hist[a][i] = '0;
    hist_pos[0] = 0;
    hist_pos[1] = 0;
    gain_now[0] = wrme_pkg::ONE_Q;
    gain_now[1] = wrme_pkg::ONE_Q;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default settings: field extremes, invalid measurement, window closes
    add_sample(32767, -32768, 32767, -32768, 1'b1, 0);
    add_sample(-32768, 32767, -32768, 32767, 1'b1, 255);
    add_sample(0, 0, 12345, -12345, 1'b0, 0);
    add_sample(5, -5, 100, 100, 1'b1, 40);
    add_sample(9, 9, 20, 20, 1'b1, 60);
    add_sample(200, -300, 400, -900, 1'b1, 255);
    add_sample(-1, 1, -1, 1, 1'b1, 1);
    drain();

    // window closes on every beat, no minimum
    write_cfg(wrme_pkg::CFG_WIN_LEN, 16'd0);
    write_cfg(wrme_pkg::CFG_MIN_REF, 16'd0);
    add_sample(0, 0, 500, 500, 1'b1, 0);
    add_sample(300, -300, 0, 0, 1'b1, 0);
    add_sample(1, -1, 32767, -32768, 1'b1, 0);
    add_sample(100, 100, 100, 200, 1'b1, 0);
    add_sample(100, 100, 300, 50, 1'b1, 0);
    add_sample(100, 100, 150, 250, 1'b1, 0);
    add_sample(100, 100, 120, 80, 1'b1, 0);
    add_sample(100, 100, 90, 110, 1'b1, 0);
    add_sample(100, 100, 95, 105, 1'b1, 0);
    add_random(150, 3);
    drain();

    // longest window and strongest minimum
    write_cfg(wrme_pkg::CFG_WIN_LEN, 16'hFFFF);
    write_cfg(wrme_pkg::CFG_MIN_REF, 16'hFFFF);
    add_random(270, 255);
    drain();

    write_cfg(wrme_pkg::CFG_WIN_LEN, 16'd40);
    write_cfg(wrme_pkg::CFG_MIN_REF, 16'd50);
    add_random(250, 15);
    drain();

    write_cfg(wrme_pkg::CFG_WIN_LEN, 16'd1);
    write_cfg(wrme_pkg::CFG_MIN_REF, 16'd1);
    add_random(40, 2);
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
